// ===== rtl/core/rhht_pkg.sv =====
`default_nettype none
package rhht_pkg;

   localparam int HASH_W   = 64;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 10;
   localparam int TSL_W    = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 10;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_ERASE  = 2'd1;
   localparam logic [OP_W-1:0] OP_FIND   = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ERASED    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;
   localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd6;

   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_SIZE_LOG2 = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ENTRIES     = 1'b1;

   localparam logic [TSL_W-1:0]   TSL_RESET     = 4'd10;
   localparam logic [COUNT_W-1:0] MAX_ENT_RESET = 10'd819;
   localparam logic [TSL_W-1:0]   TSL_MIN       = 4'd4;

endpackage
`default_nettype wire

// ===== rtl/core/rhht_slot_ram.sv =====
`default_nettype none
module rhht_slot_ram #(
   parameter int ADDR_W = 10,
   parameter int DATA_W = 139
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/core/robin_hood_hash_table_core.sv =====
// Robin Hood hash table with a fixed slot memory.
// req channel: one beat carries opcode, key, key_hash and value; req_stall is high
// whenever an operation is in flight. rsp channel: one beat per request with
// status, found_value, entry_count and longest_probe_out, held in an output
// register, so a new request can be taken while the previous result waits.
// Every slot visit is a read state and then an evaluate-and-write-back state on the
// slot memory, which has one write port and one read port:
//   find / erase lookup: at most longest_probe slots probed
//   erase shift: one more slot visit per entry moved back
//   insert: a read-only pass that decides the outcome, then, unless the table is
//           full, the writing pass, then the hand-off of the result
//   clear: one slot per cycle over the whole memory, all 2**SLOTS_LOG2 slots
// After reset the block zeroes every slot of the memory, stalling req,
// while the csr port still takes writes. A stalled rsp beat holds the finished
// result; the block then waits before loading the next one.
`default_nettype none
module robin_hood_hash_table_core #(
   parameter int SLOTS_LOG2 = 10,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [rhht_pkg::OP_W-1:0]           req_opcode,
   input  wire logic [KEY_BITS-1:0]                 req_key,
   input  wire logic [rhht_pkg::HASH_W-1:0]         req_key_hash,
   input  wire logic [VALUE_BITS-1:0]               req_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [rhht_pkg::STATUS_W-1:0]       rsp_status,
   output logic      [VALUE_BITS-1:0]               rsp_found_value,
   output logic      [rhht_pkg::COUNT_W-1:0]        rsp_entry_count,
   output logic      [SLOTS_LOG2:0]                 rsp_longest_probe_out,
   input  wire logic                                csr_we,
   input  wire logic [rhht_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [rhht_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int AW     = SLOTS_LOG2;
   localparam int DIST_W = SLOTS_LOG2 + 1;

   typedef struct packed {
      logic [DIST_W-1:0]           distance;
      logic [rhht_pkg::HASH_W-1:0] hash;
      logic [KEY_BITS-1:0]         key;
      logic [VALUE_BITS-1:0]       val;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

   typedef enum logic [8:0] {
      S_SWEEP = 9'b000000001,
      S_IDLE  = 9'b000000010,
      S_IRD   = 9'b000000100,
      S_IEV   = 9'b000001000,
      S_LRD   = 9'b000010000,
      S_LEV   = 9'b000100000,
      S_ERD   = 9'b001000000,
      S_EEV   = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic [rhht_pkg::TSL_W-1:0]    tsl_ff, tsl_in;
   logic [rhht_pkg::COUNT_W-1:0]  max_ent_ff, max_ent_in;
   logic [rhht_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [DIST_W-1:0]             longest_ff, longest_in;
   logic [AW-1:0]                 sweep_ff, sweep_in;
   logic                          clr_ff, clr_in;
   logic                          dry_ff, dry_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   logic [rhht_pkg::OP_W-1:0]     op_ff, op_in;
   logic [KEY_BITS-1:0]           key_ff, key_in;
   logic [rhht_pkg::HASH_W-1:0]   hash_ff, hash_in;
   logic [VALUE_BITS-1:0]         val_ff, val_in;
   logic [rhht_pkg::HASH_W-1:0]   ch_ff, ch_in;
   logic [KEY_BITS-1:0]           ck_ff, ck_in;
   logic [VALUE_BITS-1:0]         cv_ff, cv_in;
   logic [DIST_W-1:0]             cd_ff, cd_in;
   logic [AW-1:0]                 pos_ff, pos_in;
   logic [DIST_W-1:0]             step_ff, step_in;
   logic [rhht_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [VALUE_BITS-1:0]         res_value_ff, res_value_in;
   logic [rhht_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [VALUE_BITS-1:0]         rsp_value_ff, rsp_value_in;
   logic [rhht_pkg::COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [DIST_W-1:0]             rsp_longest_ff, rsp_longest_in;

   logic [4:0]        lg;
   logic [DIST_W-1:0] n_w;
   logic [AW-1:0]     mask;
   logic [DIST_W-1:0] span;
   logic [AW-1:0]     pos_next;
   logic [AW-1:0]     home_req;
   logic [AW-1:0]     home_ff;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   slot_type          ram_wdata;
   logic [AW-1:0]     ram_raddr;
   logic [SLOT_W-1:0] ram_rdata;
   slot_type          rd_slot;
   logic              room_full;

   // log2 of the slot count in use, clamped to TSL_MIN..SLOTS_LOG2
   always_comb begin
      priority if (tsl_ff < rhht_pkg::TSL_MIN) begin
         lg = 5'(rhht_pkg::TSL_MIN);
      end else if (5'(tsl_ff) > 5'(SLOTS_LOG2)) begin
         lg = 5'(SLOTS_LOG2);
      end else begin
         lg = 5'(tsl_ff);
      end
   end

   assign n_w      = DIST_W'(1) << lg;
   assign mask     = AW'(n_w - DIST_W'(1));
   assign span     = (longest_ff < n_w) ? longest_ff : n_w;
   assign pos_next = (pos_ff + AW'(1)) & mask;
   assign home_req = req_key_hash[AW-1:0] & mask;
   assign home_ff  = hash_ff[AW-1:0] & mask;
   assign rd_slot  = slot_type'(ram_rdata);
   assign ram_raddr = (state_ff == S_ERD) ? pos_next : pos_ff;
   assign room_full = (count_ff >= max_ent_ff) || (32'(count_ff) >= 32'(n_w));

   rhht_slot_ram #(
      .ADDR_W (AW),
      .DATA_W (SLOT_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (SLOT_W'(ram_wdata)),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in       = state_ff;
      tsl_in         = tsl_ff;
      max_ent_in     = max_ent_ff;
      count_in       = count_ff;
      longest_in     = longest_ff;
      sweep_in       = sweep_ff;
      clr_in         = clr_ff;
      dry_in         = dry_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      op_in          = op_ff;
      key_in         = key_ff;
      hash_in        = hash_ff;
      val_in         = val_ff;
      ch_in          = ch_ff;
      ck_in          = ck_ff;
      cv_in          = cv_ff;
      cd_in          = cd_ff;
      pos_in         = pos_ff;
      step_in        = step_ff;
      res_status_in  = res_status_ff;
      res_value_in   = res_value_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_longest_in = rsp_longest_ff;
      ram_we         = 1'b0;
      ram_waddr      = pos_ff;
      ram_wdata      = rd_slot;

      if (csr_we && csr_index == rhht_pkg::CSR_TABLE_SIZE_LOG2) begin
         tsl_in = csr_wdata[rhht_pkg::TSL_W-1:0];
      end
      if (csr_we && csr_index == rhht_pkg::CSR_MAX_ENTRIES) begin
         max_ent_in = csr_wdata[rhht_pkg::COUNT_W-1:0];
      end

      unique case (state_ff)
         S_SWEEP: begin
            ram_we    = 1'b1;
            ram_waddr = sweep_ff;
            ram_wdata = '0;
            sweep_in  = sweep_ff + AW'(1);
            if (sweep_ff == '1) begin
               if (clr_ff) begin
                  res_status_in = rhht_pkg::ST_CLEARED;
                  res_value_in  = '0;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in   = req_opcode;
               key_in  = req_key;
               hash_in = req_key_hash;
               val_in  = req_value;
               pos_in  = home_req;
               step_in = '0;
               ch_in   = req_key_hash;
               cd_in   = DIST_W'(1);
               dry_in  = 1'b1;
               unique case (req_opcode)
                  rhht_pkg::OP_INSERT: state_in = S_IRD;
                  rhht_pkg::OP_ERASE:  state_in = S_LRD;
                  rhht_pkg::OP_FIND:   state_in = S_LRD;
                  rhht_pkg::OP_CLEAR: begin
                     sweep_in = '0;
                     clr_in   = 1'b1;
                     count_in = '0;
                     state_in = S_SWEEP;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_IRD: begin
            if (step_ff == n_w) begin
               res_status_in = rhht_pkg::ST_FULL;
               res_value_in  = '0;
               state_in      = S_DONE;
            end else begin
               state_in = S_IEV;
            end
         end
         S_IEV: begin
            res_value_in = '0;
            if (rd_slot.distance == '0 || ch_ff == rd_slot.hash) begin
               if (dry_ff) begin
                  if (rd_slot.distance == '0 && room_full) begin
                     res_status_in = rhht_pkg::ST_FULL;
                     state_in      = S_DONE;
                  end else begin
                     // outcome known, now the writing pass
                     dry_in   = 1'b0;
                     pos_in   = home_ff;
                     step_in  = '0;
                     ch_in    = hash_ff;
                     ck_in    = key_ff;
                     cv_in    = val_ff;
                     cd_in    = DIST_W'(1);
                     state_in = S_IRD;
                  end
               end else if (rd_slot.distance == '0) begin
                  ram_we    = 1'b1;
                  ram_wdata = '{distance: cd_ff, hash: ch_ff, key: ck_ff, val: cv_ff};
                  if (cd_ff > longest_ff) begin
                     longest_in = cd_ff;
                  end
                  count_in      = count_ff + rhht_pkg::COUNT_W'(1);
                  res_status_in = rhht_pkg::ST_INSERTED;
                  state_in      = S_DONE;
               end else begin
                  ram_we        = 1'b1;
                  ram_wdata     = rd_slot;
                  ram_wdata.val = cv_ff;
                  res_status_in = rhht_pkg::ST_UPDATED;
                  state_in      = S_DONE;
               end
            end else begin
               if (cd_ff > rd_slot.distance) begin
                  // richer resident gives way to the carried entry
                  if (!dry_ff) begin
                     ram_we    = 1'b1;
                     ram_wdata = '{distance: cd_ff, hash: ch_ff, key: ck_ff, val: cv_ff};
                     if (cd_ff > longest_ff) begin
                        longest_in = cd_ff;
                     end
                  end
                  ch_in = rd_slot.hash;
                  ck_in = rd_slot.key;
                  cv_in = rd_slot.val;
                  cd_in = rd_slot.distance + DIST_W'(1);
               end else begin
                  cd_in = cd_ff + DIST_W'(1);
               end
               pos_in   = pos_next;
               step_in  = step_ff + DIST_W'(1);
               state_in = S_IRD;
            end
         end
         S_LRD: begin
            if (step_ff >= span) begin
               res_status_in = rhht_pkg::ST_NOT_FOUND;
               res_value_in  = '0;
               state_in      = S_DONE;
            end else begin
               state_in = S_LEV;
            end
         end
         S_LEV: begin
            if (rd_slot.distance != '0 && rd_slot.hash == hash_ff &&
                rd_slot.key == key_ff) begin
               if (op_ff == rhht_pkg::OP_FIND) begin
                  res_status_in = rhht_pkg::ST_FOUND;
                  res_value_in  = rd_slot.val;
                  state_in      = S_DONE;
               end else begin
                  step_in  = '0;
                  state_in = S_ERD;
               end
            end else begin
               pos_in   = pos_next;
               step_in  = step_ff + DIST_W'(1);
               state_in = S_LRD;
            end
         end
         S_ERD: begin
            if (step_ff == n_w) begin
               ram_we    = 1'b1;
               ram_wdata = '0;
               if (count_ff != '0) begin
                  count_in = count_ff - rhht_pkg::COUNT_W'(1);
               end
               res_status_in = rhht_pkg::ST_ERASED;
               res_value_in  = '0;
               state_in      = S_DONE;
            end else begin
               state_in = S_EEV;
            end
         end
         S_EEV: begin
            ram_we = 1'b1;
            if (rd_slot.distance > DIST_W'(1)) begin
               // pull the displaced entry back into the hole
               ram_wdata          = rd_slot;
               ram_wdata.distance = rd_slot.distance - DIST_W'(1);
               pos_in             = pos_next;
               step_in            = step_ff + DIST_W'(1);
               state_in           = S_ERD;
            end else begin
               ram_wdata = '0;
               if (count_ff != '0) begin
                  count_in = count_ff - rhht_pkg::COUNT_W'(1);
               end
               res_status_in = rhht_pkg::ST_ERASED;
               res_value_in  = '0;
               state_in      = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_value_in   = res_value_ff;
               rsp_count_in   = count_ff;
               rsp_longest_in = longest_ff;
               clr_in         = 1'b0;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         tsl_ff       <= rhht_pkg::TSL_RESET;
         max_ent_ff   <= rhht_pkg::MAX_ENT_RESET;
         count_ff     <= '0;
         longest_ff   <= '0;
         sweep_ff     <= '0;
         clr_ff       <= 1'b0;
         dry_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tsl_ff       <= tsl_in;
         max_ent_ff   <= max_ent_in;
         count_ff     <= count_in;
         longest_ff   <= longest_in;
         sweep_ff     <= sweep_in;
         clr_ff       <= clr_in;
         dry_ff       <= dry_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      key_ff         <= key_in;
      hash_ff        <= hash_in;
      val_ff         <= val_in;
      ch_ff          <= ch_in;
      ck_ff          <= ck_in;
      cv_ff          <= cv_in;
      cd_ff          <= cd_in;
      pos_ff         <= pos_in;
      step_ff        <= step_in;
      res_status_ff  <= res_status_in;
      res_value_ff   <= res_value_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_longest_ff <= rsp_longest_in;
   end

   assign req_stall             = (state_ff != S_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_found_value       = rsp_value_ff;
   assign rsp_entry_count       = rsp_count_ff;
   assign rsp_longest_probe_out = rsp_longest_ff;

   // a result beat only appears out of the hand-off state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("rsp beat raised outside hand-off");

   // the deciding pass of an insert never touches the memory
   a_dry_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IEV && dry_ff) |-> !ram_we)
      else $error("slot write during insert dry run");

   // longest probe only grows between resets
   a_longest_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> longest_ff >= $past(longest_ff))
      else $error("longest probe decreased");

endmodule
`default_nettype wire
